### rtl/core/fbud_pkg.sv
// Shared constants and types for the flag/byte-unstuffing deframer.
// Used by fbud_core and flag_byte_unstuffing_deframer; no dependencies.
package fbud_pkg;

    localparam int MAX_FRAME_BYTES = 256;
    // raw count saturates at MAX_FRAME_BYTES + 1
    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 2);

    localparam logic [7:0] FLAG_BYTE     = 8'h7E;
    localparam logic [7:0] ESC_BYTE      = 8'h7D;
    localparam logic [7:0] ESC_FLAG_CODE = 8'h02;

    localparam logic [7:0] MIN_FRAME_RESET = 8'd7;
    localparam logic       CHECK_EN_RESET  = 1'b1;

    localparam logic [7:0] REG_MIN_FRAME = 8'd0;
    localparam logic [7:0] REG_CHECK_EN  = 8'd1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_CUT_ESC  = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef struct packed {
        logic       valid;
        logic [7:0] out_byte;
        logic       is_check_byte;
        logic       frame_end;
        logic [1:0] frame_status;
    } result_t;

endpackage

### rtl/core/fbud_core.sv
// Frame state and per-byte decode for the deframer.
// Depends on fbud_pkg; instantiated by flag_byte_unstuffing_deframer.
module fbud_core (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    step,
    input  logic [7:0]              rx_byte,
    input  logic [7:0]              min_frame_bytes,
    input  logic                    check_enable,
    output fbud_pkg::result_t       result
);

    logic                       in_frame_reg, in_frame_next;
    logic                       esc_reg, esc_next;
    logic [fbud_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       have_chk_reg, have_chk_next;
    logic [7:0]                 chk_reg, chk_next;
    logic [7:0]                 sum_reg, sum_next;
    logic                       ovf_reg, ovf_next;

    logic [fbud_pkg::CNT_W-1:0] cnt_inc;
    logic                       ovf_inc;
    logic                       is_flag;
    logic                       closing;
    logic [7:0]                 dec;

    always_comb begin
        in_frame_next = in_frame_reg;
        esc_next      = esc_reg;
        cnt_next      = cnt_reg;
        have_chk_next = have_chk_reg;
        chk_next      = chk_reg;
        sum_next      = sum_reg;
        ovf_next      = ovf_reg;
        result        = '0;

        is_flag = (rx_byte == fbud_pkg::FLAG_BYTE);
        cnt_inc = (cnt_reg < fbud_pkg::CNT_W'(fbud_pkg::MAX_FRAME_BYTES + 1))
                  ? cnt_reg + 1'b1 : cnt_reg;
        ovf_inc = ovf_reg || (cnt_inc > fbud_pkg::CNT_W'(fbud_pkg::MAX_FRAME_BYTES));
        // count is at least 2 here, so a minimum below 2 acts as 2
        closing = is_flag && (cnt_inc >= fbud_pkg::CNT_W'(min_frame_bytes));
        dec     = esc_reg ? ((rx_byte == fbud_pkg::ESC_FLAG_CODE) ? fbud_pkg::FLAG_BYTE
                                                                  : fbud_pkg::ESC_BYTE)
                          : rx_byte;

        if (step) begin
            if (!in_frame_reg) begin
                if (is_flag) begin
                    in_frame_next = 1'b1;
                    esc_next      = 1'b0;
                    cnt_next      = fbud_pkg::CNT_W'(1);
                    have_chk_next = 1'b0;
                    chk_next      = '0;
                    sum_next      = '0;
                    ovf_next      = 1'b0;
                end
            end else if (closing) begin
                result.valid     = 1'b1;
                result.out_byte  = fbud_pkg::FLAG_BYTE;
                result.frame_end = 1'b1;
                if (ovf_inc)
                    result.frame_status = fbud_pkg::ST_OVERFLOW;
                else if (esc_reg)
                    result.frame_status = fbud_pkg::ST_CUT_ESC;
                else if (check_enable && (!have_chk_reg || sum_reg != chk_reg))
                    result.frame_status = fbud_pkg::ST_MISMATCH;
                else
                    result.frame_status = fbud_pkg::ST_OK;
                in_frame_next = 1'b0;
                esc_next      = 1'b0;
                cnt_next      = '0;
                have_chk_next = 1'b0;
                chk_next      = '0;
                sum_next      = '0;
                ovf_next      = 1'b0;
            end else begin
                cnt_next = cnt_inc;
                ovf_next = ovf_inc;
                if (!esc_reg && rx_byte == fbud_pkg::ESC_BYTE) begin
                    esc_next = 1'b1;
                end else begin
                    esc_next = 1'b0;
                    // overflowed frames swallow data bytes
                    if (!ovf_inc) begin
                        result.valid    = 1'b1;
                        result.out_byte = dec;
                        if (!have_chk_reg) begin
                            have_chk_next        = 1'b1;
                            chk_next             = dec;
                            result.is_check_byte = 1'b1;
                        end else begin
                            sum_next = sum_reg + dec;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            esc_reg      <= 1'b0;
            cnt_reg      <= '0;
            have_chk_reg <= 1'b0;
            chk_reg      <= '0;
            sum_reg      <= '0;
            ovf_reg      <= 1'b0;
        end else begin
            in_frame_reg <= in_frame_next;
            esc_reg      <= esc_next;
            cnt_reg      <= cnt_next;
            have_chk_reg <= have_chk_next;
            chk_reg      <= chk_next;
            sum_reg      <= sum_next;
            ovf_reg      <= ovf_next;
        end
    end

endmodule

### rtl/core/flag_byte_unstuffing_deframer.sv
// Top level of the flag-delimited byte-unstuffing deframer with sum check.
// Depends on fbud_pkg and fbud_core.
//
// Raw bytes enter on the s_ channel, one request per cycle while m_ready does
// not hold the output back. Each byte is registered in an input register, is
// decoded against the frame state and lands in the output register, which
// offers its result on m_. s_ready follows m_ready through the input
// register: a byte is taken while a result waits only if the byte ahead can
// move into a free or draining output register. Bytes that give no result
// (idle line, escape codes, overflow) give no transfer on m_.
// Configuration (index 0 min_frame_bytes, 1 check_enable) is always ready and
// should only be written while the block is idle.
module flag_byte_unstuffing_deframer (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_is_check_byte,
    output logic       m_frame_end,
    output logic [1:0] m_frame_status,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_index,
    input  logic [7:0] cfg_data
);

    logic [7:0]        min_frame_reg;
    logic              check_en_reg;
    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    fbud_pkg::result_t out_reg;
    fbud_pkg::result_t dec_res;
    logic              advance;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_reg.valid || m_ready);
    assign s_ready   = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_frame_reg <= fbud_pkg::MIN_FRAME_RESET;
            check_en_reg  <= fbud_pkg::CHECK_EN_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                fbud_pkg::REG_MIN_FRAME: min_frame_reg <= cfg_data;
                fbud_pkg::REG_CHECK_EN:  check_en_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid)
            in_byte_reg <= s_rx_byte;
    end

    fbud_core u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step            (advance),
        .rx_byte         (in_byte_reg),
        .min_frame_bytes (min_frame_reg),
        .check_enable    (check_en_reg),
        .result          (dec_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg <= '0;
        end else if (advance) begin
            out_reg <= dec_res;
        end else if (m_ready) begin
            out_reg.valid <= 1'b0;
        end
    end

    assign m_valid         = out_reg.valid;
    assign m_out_byte      = out_reg.out_byte;
    assign m_is_check_byte = out_reg.is_check_byte;
    assign m_frame_end     = out_reg.frame_end;
    assign m_frame_status  = out_reg.frame_status;

endmodule
